// ----- hdl/tlc_pkg.sv -----
package tlc_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       hit;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FILL,
        ST_ACCESS,
        ST_RESP
    } t_state;

    localparam int unsigned REQ_ADDR_BITS = 16;
    localparam logic        MODE_WRITE    = 1'b1;

endpackage

// ----- hdl/tlc_ram.sv -----
module tlc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ----- hdl/two_way_lru_writeback_cache.sv -----
// Two-way set-associative write-back cache with a private backing memory.
// Request channel: i_req_valid / o_req_ready carrying t_req (mode, address,
// write_data). Response channel: o_rsp_valid / i_rsp_ready carrying t_rsp
// (read_data, hit). Each request gives exactly one response, in order.
// One request is in flight at a time. On a hit it passes through the tag RAM
// read, compare, line RAM access and response register before o_rsp_valid
// rises, and the next request is accepted after the response register loads.
// A clean miss adds a line fill from the backing memory; a dirty victim adds
// a write-back of the old line first. Both run one byte per cycle through
// the single-port line RAM and backing RAM.
// After reset, valid, dirty and LRU state clear at once, and a clearing pass
// writes zero to every address of the backing memory, with o_req_ready
// low. When the receiver stalls, the response waits in the output register;
// one more request can still be accepted and processed, and it then holds in
// its response state until the output register is free.
module two_way_lru_writeback_cache
    import tlc_pkg::*;
#(
    parameter int unsigned SETS       = 16,
    parameter int unsigned LINE_BYTES = 32,
    parameter int unsigned ADDR_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int unsigned OFF_BITS = $clog2(LINE_BYTES);
    localparam int unsigned SET_BITS = $clog2(SETS);
    localparam int unsigned TAG_BITS = ADDR_BITS - OFF_BITS - SET_BITS;
    localparam int unsigned LINE_AW  = SET_BITS + 1 + OFF_BITS;

    t_state r_state, n_state;

    logic [ADDR_BITS-1:0] w_in_addr;
    generate
        if (ADDR_BITS > REQ_ADDR_BITS) begin : g_ext
            assign w_in_addr = {{(ADDR_BITS-REQ_ADDR_BITS){1'b0}}, i_req.address};
        end else begin : g_trunc
            assign w_in_addr = i_req.address[ADDR_BITS-1:0];
        end
    endgenerate

    logic                  r_mode;
    logic [7:0]            r_wdata;
    logic [TAG_BITS-1:0]   r_tag;
    logic [SET_BITS-1:0]   r_set;
    logic [OFF_BITS-1:0]   r_off;
    logic                  r_way;
    logic                  r_hit;
    logic [2*TAG_BITS-1:0] r_tags;
    logic [OFF_BITS:0]     r_cnt;
    logic [ADDR_BITS-1:0]  r_clr;
    logic [SETS-1:0][1:0]  r_valid;
    logic [SETS-1:0][1:0]  r_dirty;
    logic [SETS-1:0]       r_lru;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [2*TAG_BITS-1:0] w_tag_q;
    logic [7:0]            w_line_q;
    logic [7:0]            w_mem_q;

    logic                  w_tag_we;
    logic [SET_BITS-1:0]   w_tag_addr;
    logic [2*TAG_BITS-1:0] w_tag_wd;
    logic                  w_line_we;
    logic [LINE_AW-1:0]    w_line_addr;
    logic [7:0]            w_line_wd;
    logic                  w_mem_we;
    logic [ADDR_BITS-1:0]  w_mem_addr;
    logic [7:0]            w_mem_wd;
    logic                  w_accept;
    logic                  w_out_free;

    logic [TAG_BITS-1:0]   w_t0, w_t1;
    logic                  w_v0, w_v1, w_hit0, w_hit1, w_hit, w_way, w_dirty_victim;
    logic [OFF_BITS-1:0]   w_cm1;
    logic                  w_cnt_end;

    assign w_t0   = w_tag_q[TAG_BITS-1:0];
    assign w_t1   = w_tag_q[2*TAG_BITS-1:TAG_BITS];
    assign w_v0   = r_valid[r_set][0];
    assign w_v1   = r_valid[r_set][1];
    assign w_hit0 = w_v0 && (w_t0 == r_tag);
    assign w_hit1 = w_v1 && (w_t1 == r_tag);
    assign w_hit  = w_hit0 || w_hit1;

    always_comb begin
        priority if (w_hit0) begin
            w_way = 1'b0;
        end else if (w_hit1) begin
            w_way = 1'b1;
        end else if (!w_v0) begin
            w_way = 1'b0;
        end else if (!w_v1) begin
            w_way = 1'b1;
        end else begin
            w_way = r_lru[r_set];
        end
    end

    assign w_dirty_victim = !w_hit && r_valid[r_set][w_way] && r_dirty[r_set][w_way];
    assign w_cm1      = r_cnt[OFF_BITS-1:0] - {{(OFF_BITS-1){1'b0}}, 1'b1};
    assign w_cnt_end  = r_cnt[OFF_BITS];
    assign w_out_free = !r_out_valid || i_rsp_ready;
    assign w_accept   = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                priority if (w_hit) begin
                    n_state = ST_ACCESS;
                end else if (w_dirty_victim) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_WB: begin
                if (w_cnt_end) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (w_cnt_end) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: n_state = ST_RESP;
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        w_tag_we    = 1'b0;
        w_tag_addr  = r_set;
        w_tag_wd    = r_tags;
        w_line_we   = 1'b0;
        w_line_addr = {r_set, r_way, r_off};
        w_line_wd   = r_wdata;
        w_mem_we    = 1'b0;
        w_mem_addr  = {r_tag, r_set, r_cnt[OFF_BITS-1:0]};
        w_mem_wd    = w_line_q;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_clr;
                w_mem_wd   = 8'd0;
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                w_tag_addr  = w_in_addr[OFF_BITS +: SET_BITS];
            end
            ST_WB: begin
                w_line_addr = {r_set, r_way, r_cnt[OFF_BITS-1:0]};
                w_mem_we    = (r_cnt != '0);
                w_mem_addr  = r_way ? {r_tags[2*TAG_BITS-1:TAG_BITS], r_set, w_cm1}
                                    : {r_tags[TAG_BITS-1:0], r_set, w_cm1};
            end
            ST_FILL: begin
                w_line_addr = {r_set, r_way, w_cm1};
                w_line_we   = (r_cnt != '0);
                w_line_wd   = w_mem_q;
                if (w_cnt_end) begin
                    w_tag_we = 1'b1;
                    w_tag_wd = r_way ? {r_tag, r_tags[TAG_BITS-1:0]}
                                     : {r_tags[2*TAG_BITS-1:TAG_BITS], r_tag};
                end
            end
            ST_ACCESS: begin
                w_line_we = (r_mode == MODE_WRITE);
            end
            ST_LOOKUP, ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_lru       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_RESP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOOKUP: r_cnt <= '0;
                ST_WB: r_cnt <= w_cnt_end ? '0 : r_cnt + 1'b1;
                ST_FILL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_cnt_end) begin
                        r_valid[r_set][r_way] <= 1'b1;
                        r_dirty[r_set][r_way] <= 1'b0;
                    end
                end
                ST_ACCESS: begin
                    r_lru[r_set] <= ~r_way;
                    if (r_mode == MODE_WRITE) begin
                        r_dirty[r_set][r_way] <= 1'b1;
                    end
                end
                ST_CLEAR, ST_IDLE, ST_RESP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_req.mode;
            r_wdata <= i_req.write_data;
            r_off   <= w_in_addr[OFF_BITS-1:0];
            r_set   <= w_in_addr[OFF_BITS +: SET_BITS];
            r_tag   <= w_in_addr[ADDR_BITS-1 -: TAG_BITS];
        end
        if (r_state == ST_LOOKUP) begin
            r_way  <= w_way;
            r_hit  <= w_hit;
            r_tags <= w_tag_q;
        end
        if (r_state == ST_RESP && w_out_free) begin
            r_out.hit       <= r_hit;
            r_out.read_data <= (r_mode == MODE_WRITE) ? r_wdata : w_line_q;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    tlc_ram #(.WIDTH(2*TAG_BITS), .AW(SET_BITS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_addr  (w_tag_addr),
        .i_wdata (w_tag_wd),
        .o_rdata (w_tag_q)
    );

    tlc_ram #(.WIDTH(8), .AW(LINE_AW)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_addr  (w_line_addr),
        .i_wdata (w_line_wd),
        .o_rdata (w_line_q)
    );

    tlc_ram #(.WIDTH(8), .AW(ADDR_BITS)) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wd),
        .o_rdata (w_mem_q)
    );

endmodule
